// ===== hw/rtl/tbba_pkg.sv =====
// Package for the two-level bitmap ID allocator: sizes, operation codes,
// item types and the lowest-zero search. No dependencies.
`default_nettype none
package tbba_pkg;

  // Pool geometry
  localparam int NUM_WORDS = 64;
  localparam int WORD_BITS = 64;
  localparam int WORD_AW   = $clog2(NUM_WORDS);
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int NUM_W     = WORD_AW + BIT_AW;
  localparam int CAPACITY  = NUM_WORDS * WORD_BITS;

  // Item field widths
  localparam int FUNC_W   = 3;
  localparam int NUMBER_W = 16;
  localparam int LENT_W   = 12;

  // Numbers compared one bit wider so that a full-range pool still fits
  localparam logic [NUMBER_W:0] CAP_EXT  = (NUMBER_W + 1)'(CAPACITY);
  localparam logic [NUM_W-1:0]  LAST_NUM = NUM_W'(CAPACITY - 1);

  // Summary bits beyond the pool are held set so that lend never picks them
  localparam logic [WORD_BITS-1:0] SUM_RESET =
    ~({WORD_BITS{1'b1}} >> (WORD_BITS - NUM_WORDS));

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_LEND         = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RETURN       = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ASSIGN       = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ASSIGN_RANGE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RETURN_RANGE = 3'd4;

  // Word pass codes for the shared word unit
  typedef logic [1:0] pass_t;
  localparam pass_t PASS_CHECK = 2'd0;
  localparam pass_t PASS_SET   = 2'd1;
  localparam pass_t PASS_CLEAR = 2'd2;
  localparam pass_t PASS_LEND  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [NUMBER_W-1:0] number;
    logic [NUMBER_W-1:0] end_number;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [LENT_W-1:0] lent_number;
  } rsp_t;

  typedef struct packed {
    logic              clash;
    logic              full;
    logic [BIT_AW-1:0] zero_idx;
  } wu_status_t;

  // Lowest clear bit: {none_clear, index}
  function automatic logic [BIT_AW:0] lowest_zero(input logic [WORD_BITS-1:0] v);
    logic              none;
    logic [BIT_AW-1:0] idx;
    none = 1'b1;
    idx  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        none = 1'b0;
        idx  = BIT_AW'(i);
      end
    end
    return {none, idx};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tbba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tbba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tbba_word_unit.sv =====
// Shared word unit: builds the range mask for one word and applies a check,
// set, clear or lend to it. Depends on tbba_pkg.
`default_nettype none
module tbba_word_unit
  import tbba_pkg::*;
(
  input  wire pass_t                  pass,
  input  wire logic [WORD_AW-1:0]     word_idx,
  input  wire logic [NUM_W-1:0]       s,
  input  wire logic [NUM_W-1:0]       e,
  input  wire logic [WORD_BITS-1:0]   data_in,
  output      logic [WORD_BITS-1:0]   word_out,
  output      wu_status_t             status
);

  logic [BIT_AW-1:0]    lo;
  logic [BIT_AW-1:0]    hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] lend_bit;
  logic [BIT_AW:0]      lz;

  // Trim the mask at the first and last words of the range
  assign lo = (word_idx == s[NUM_W-1:BIT_AW]) ? s[BIT_AW-1:0] : '0;
  assign hi = (word_idx == e[NUM_W-1:BIT_AW]) ? e[BIT_AW-1:0] : BIT_AW'(WORD_BITS - 1);
  assign mask = ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - hi))
              & ({WORD_BITS{1'b1}} << lo);

  // Isolate the lowest clear bit
  assign lend_bit = ~data_in & (data_in + WORD_BITS'(1));
  assign lz       = lowest_zero(data_in);

  always_comb begin
    case (pass)
      PASS_SET:   word_out = data_in | mask;
      PASS_CLEAR: word_out = data_in & ~mask;
      PASS_LEND:  word_out = data_in | lend_bit;
      default:    word_out = data_in;
    endcase
  end

  assign status.clash    = |(data_in & mask);
  assign status.full     = &word_out;
  assign status.zero_idx = lz[BIT_AW-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/two_level_bitmap_id_allocator.sv =====
// Top level of the two-level bitmap ID allocator: sequencer, summary bitmap,
// word-valid bits. Depends on tbba_pkg, tbba_ram and tbba_word_unit.
`default_nettype none
// Usage
//   Command channel: drive req and raise start; the item is taken at the
//   rising edge where start is high and busy is low. busy stays high until
//   the result is delivered.
//   Result channel: done pulses for one cycle with rsp; there is no
//   backpressure, so the receiver must capture rsp in that cycle. A new
//   item may be started in the same cycle that done is high.
// Sequence
//   Rejected or empty items (bad func, full pool, out of range, reversed
//   range) pass through S_FIN only. Other items read a word in S_READ and
//   then sweep words in S_EVAL: lend and return one touch one word, assign
//   one makes a check pass then a set pass, return range clears word by word,
//   and assign range makes a check sweep, then a write sweep; a clash ends it
//   early. The single read port of the used-word RAM, with registered read
//   data, delivers one word per cycle to the shared word unit.
// Reset
//   Synchronous, active high. Clears the sequencer, the summary bitmap and
//   the per-word valid bits; a word that was never written reads as all
//   free, so no clearing sweep of the RAM is needed.
module two_level_bitmap_id_allocator
  import tbba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output      logic busy,
  input  wire req_t req,
  output      logic done,
  output      rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]           state, state_next;
  logic [WORD_AW-1:0]   w, w_next;
  pass_t                pass, pass_next;
  logic [NUM_W-1:0]     s, s_next;
  logic [NUM_W-1:0]     e, e_next;
  rsp_t                 rsp_next;
  logic                 done_next;
  logic [WORD_BITS-1:0] summary;
  logic [NUM_WORDS-1:0] valid;

  logic [WORD_AW-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] word_out;
  logic                 wr_en;
  wu_status_t           wu_status;

  logic [BIT_AW:0]      sum_lz;
  logic [NUMBER_W:0]    num_ext;
  logic [NUMBER_W:0]    end_ext;
  logic                 num_in_cap;
  logic                 end_in_cap;
  logic                 ordered;
  logic                 at_last;
  logic [WORD_AW-1:0]   s_word;

  tbba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_used (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (w),
    .wr_data (word_out),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A word never written holds no used numbers
  assign word_in = valid[w] ? rd_data : '0;

  tbba_word_unit u_word (
    .pass     (pass),
    .word_idx (w),
    .s        (s),
    .e        (e),
    .data_in  (word_in),
    .word_out (word_out),
    .status   (wu_status)
  );

  assign busy       = (state != S_IDLE);
  assign sum_lz     = lowest_zero(summary);
  assign num_ext    = {1'b0, req.number};
  assign end_ext    = {1'b0, req.end_number};
  assign num_in_cap = (num_ext < CAP_EXT);
  assign end_in_cap = (end_ext < CAP_EXT);
  assign ordered    = (req.number <= req.end_number);
  assign s_word     = s[NUM_W-1:BIT_AW];
  assign at_last    = (pass == PASS_LEND) || (w == e[NUM_W-1:BIT_AW]);
  assign wr_en      = (state == S_EVAL) && (pass != PASS_CHECK);

  always_comb begin
    state_next = state;
    w_next     = w;
    pass_next  = pass;
    s_next     = s;
    e_next     = e;
    rsp_next   = rsp;
    done_next  = 1'b0;
    rd_addr    = w;

    case (state)
      S_IDLE: begin
        if (start) begin
          rsp_next   = '0;
          state_next = S_FIN;
          s_next     = req.number[NUM_W-1:0];
          e_next     = req.number[NUM_W-1:0];
          w_next     = req.number[NUM_W-1:BIT_AW];
          case (req.func)
            FN_LEND: begin
              // Take the first word whose summary bit says it has room
              if (!sum_lz[BIT_AW]) begin
                w_next     = WORD_AW'(sum_lz[BIT_AW-1:0]);
                pass_next  = PASS_LEND;
                state_next = S_READ;
              end
            end
            FN_RETURN: begin
              if (num_in_cap) begin
                pass_next  = PASS_CLEAR;
                state_next = S_READ;
              end
            end
            FN_ASSIGN: begin
              if (num_in_cap) begin
                pass_next  = PASS_CHECK;
                state_next = S_READ;
              end
            end
            FN_ASSIGN_RANGE: begin
              if (ordered && end_in_cap) begin
                e_next     = req.end_number[NUM_W-1:0];
                pass_next  = PASS_CHECK;
                state_next = S_READ;
              end
            end
            FN_RETURN_RANGE: begin
              // Free only the part inside the pool; a range wholly outside
              // succeeds with nothing to do
              if (ordered) begin
                rsp_next.ok = 1'b1;
                if (num_in_cap) begin
                  e_next     = end_in_cap ? req.end_number[NUM_W-1:0] : LAST_NUM;
                  pass_next  = PASS_CLEAR;
                  state_next = S_READ;
                end
              end
            end
            default: begin
              rsp_next.ok = 1'b0;
            end
          endcase
        end
      end

      S_READ: begin
        state_next = S_EVAL;
      end

      S_EVAL: begin
        case (pass)
          PASS_CHECK: begin
            if (wu_status.clash) begin
              rsp_next.ok = 1'b0;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else if (at_last) begin
              // Range is free: restart at the first word and claim it
              pass_next = PASS_SET;
              w_next    = s_word;
              rd_addr   = s_word;
            end else begin
              w_next  = w + WORD_AW'(1);
              rd_addr = w + WORD_AW'(1);
            end
          end
          default: begin
            if (at_last) begin
              rsp_next.ok = 1'b1;
              if (pass == PASS_LEND) begin
                rsp_next.lent_number = LENT_W'({w, wu_status.zero_idx});
              end
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else begin
              w_next  = w + WORD_AW'(1);
              rd_addr = w + WORD_AW'(1);
            end
          end
        endcase
      end

      S_FIN: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      summary <= SUM_RESET;
      valid   <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (wr_en) begin
        // Keep the summary bit in step with the word just written
        summary[w] <= wu_status.full;
        valid[w]   <= 1'b1;
      end
    end
    w    <= w_next;
    pass <= pass_next;
    s    <= s_next;
    e    <= e_next;
    rsp  <= rsp_next;
  end

  // A result only ever closes a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding busy cycle");

  // An accepted item always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // A handed-out number implies success
  a_lent_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.lent_number != '0)) |-> rsp.ok)
    else $error("lent number reported on a failed item");

  // The used-word store is only written while an item is in flight
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (busy && !done))
    else $error("used-word write outside an item");

endmodule
`default_nettype wire

// ===== sim/two_level_bitmap_id_allocator_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the two-level bitmap ID allocator: keeps its own copy of
// the pool, predicts each accepted item and compares every result in order.
// Depends on tbba_pkg.
module two_level_bitmap_id_allocator_checker
  import tbba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding
);

  logic [WORD_BITS-1:0] pool_words [NUM_WORDS];
  logic [WORD_BITS-1:0] full_words;
  rsp_t                 awaited_rsps [$];
  int                   errors = 0;

  // Keep the summary bit in step with its word
  function automatic void refresh_summary(input int w);
    full_words[w] = &pool_words[w];
  endfunction

  // Bits of word w that fall inside s..e
  function automatic logic [WORD_BITS-1:0] span_bits(input int w, input int s, input int e);
    int lo;
    int hi;
    lo = (w == s / WORD_BITS) ? s % WORD_BITS : 0;
    hi = (w == e / WORD_BITS) ? e % WORD_BITS : WORD_BITS - 1;
    return ({WORD_BITS{1'b1}} >> (WORD_BITS - 1 - hi)) & ({WORD_BITS{1'b1}} << lo);
  endfunction

  function automatic rsp_t apply_allocator_op(input req_t r);
    rsp_t res;
    int   s;
    int   e;
    int   w;
    int   last;
    int   b;
    logic clash;
    logic found;
    res   = '0;
    s     = int'(r.number);
    e     = int'(r.end_number);
    clash = 1'b0;
    found = 1'b0;
    case (r.func)
      FN_LEND: begin
        for (w = 0; w < NUM_WORDS && !found; w++) begin
          if (!full_words[w]) begin
            found = 1'b1;
            b = -1;
            for (int i = WORD_BITS - 1; i >= 0; i--)
              if (!pool_words[w][i]) b = i;
            if (b >= 0) begin
              pool_words[w][b] = 1'b1;
              refresh_summary(w);
              res.ok          = 1'b1;
              res.lent_number = LENT_W'(w * WORD_BITS + b);
            end
          end
        end
      end
      FN_RETURN: begin
        if (s < CAPACITY) begin
          w = s / WORD_BITS;
          pool_words[w][s % WORD_BITS] = 1'b0;
          refresh_summary(w);
          res.ok = 1'b1;
        end
      end
      FN_ASSIGN: begin
        if (s < CAPACITY) begin
          w = s / WORD_BITS;
          if (!pool_words[w][s % WORD_BITS]) begin
            pool_words[w][s % WORD_BITS] = 1'b1;
            refresh_summary(w);
            res.ok = 1'b1;
          end
        end
      end
      FN_ASSIGN_RANGE: begin
        if (s <= e && e < CAPACITY) begin
          for (w = s / WORD_BITS; w <= e / WORD_BITS; w++)
            if ((pool_words[w] & span_bits(w, s, e)) != '0) clash = 1'b1;
          if (!clash) begin
            for (w = s / WORD_BITS; w <= e / WORD_BITS; w++) begin
              pool_words[w] |= span_bits(w, s, e);
              refresh_summary(w);
            end
            res.ok = 1'b1;
          end
        end
      end
      FN_RETURN_RANGE: begin
        if (s <= e) begin
          last = (e / WORD_BITS < NUM_WORDS) ? e / WORD_BITS : NUM_WORDS - 1;
          for (w = s / WORD_BITS; w <= last; w++) begin
            pool_words[w] &= ~span_bits(w, s, e);
            refresh_summary(w);
          end
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      for (int i = 0; i < NUM_WORDS; i++) pool_words[i] = '0;
      full_words = '0;
      awaited_rsps.delete();
    end else begin
      // Results first: a new item may be taken at the same edge
      if (done) begin
        if (awaited_rsps.size() == 0) begin
          $error("unexpected result: ok %0d, lent_number %0d", rsp.ok, rsp.lent_number);
          errors++;
        end else begin
          exp_rsp = awaited_rsps.pop_front();
          if (rsp.ok !== exp_rsp.ok) begin
            $error("ok: expected %0d, actual %0d", exp_rsp.ok, rsp.ok);
            errors++;
          end
          if (rsp.lent_number !== exp_rsp.lent_number) begin
            $error("lent_number: expected %0d, actual %0d",
                   exp_rsp.lent_number, rsp.lent_number);
            errors++;
          end
        end
      end
      if (start && !busy) awaited_rsps.push_back(apply_allocator_op(req));
    end
    outstanding <= awaited_rsps.size();
    fail_count  <= errors;
  end

endmodule

// ===== sim/two_level_bitmap_id_allocator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the two-level bitmap ID allocator: drives directed and
// random items and gives the verdict. Depends on tbba_pkg, the allocator RTL
// and two_level_bitmap_id_allocator_checker.
module two_level_bitmap_id_allocator_tb;
  import tbba_pkg::*;

  // Function codes the block must reject
  localparam logic [FUNC_W-1:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int QUIET_ITEMS   = 150;   // tail of the run with no idling
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 140;   // longer than a whole-pool assign range

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  int   fail_count;
  int   outstanding;
  logic gaps_on;

  two_level_bitmap_id_allocator dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  two_level_bitmap_id_allocator_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Hand one item to the block. Optionally drop start for a burst of idle
  // cycles first, then hold start high until the item is taken. start is left
  // high on return so back-to-back items keep it raised without a glitch.
  task automatic issue(input logic [FUNC_W-1:0] f, input int n, input int e);
    req_t item;
    item.func       = f;
    item.number     = NUMBER_W'(n);
    item.end_number = NUMBER_W'(e);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
  endtask

  // Numbers lean towards the low words, where lends land, so that returns and
  // assigns keep meeting numbers in use; a share falls beyond the pool.
  function automatic int pick_number();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom_range(0, 511);
    else if (sel < 85) return $urandom_range(0, CAPACITY - 1);
    else return $urandom_range(CAPACITY, 65535);
  endfunction

  // Pick one of the function codes the block must reject
  function automatic logic [FUNC_W-1:0] pick_unused_func();
    return FUNC_W'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
  endfunction

  // Ranges are mostly short; a few span much of the pool, cross its end or
  // run backwards.
  task automatic pick_range(output int s, output int e);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      s = $urandom_range(0, 1023);
      e = s + $urandom_range(0, 63);
    end else if (sel < 85) begin
      s = $urandom_range(0, CAPACITY - 1);
      e = s + $urandom_range(0, 639);
    end else if (sel < 92) begin
      s = $urandom_range(0, CAPACITY - 1);
      e = $urandom_range(s, CAPACITY - 1);
    end else if (sel < 96) begin
      s = $urandom_range(0, 65535);
      e = $urandom_range(s, 65535);
    end else begin
      e = $urandom_range(0, 65534);
      s = $urandom_range(e + 1, 65535);
    end
    if (e > 65535) e = 65535;
  endtask

  initial begin
    int sel;
    int s;
    int e;
    int waited;
    rst     <= 1'b1;
    start   <= 1'b0;
    req     <= '0;
    gaps_on = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: edges of the fields, every operation, every corner
    issue(FN_RETURN_RANGE, 0, 65535);              // clear all, part beyond pool
    issue(FN_LEND, 0, 0);                          // lowest free: 0
    issue(FN_LEND, 0, 0);                          // then 1
    issue(FN_ASSIGN, 5, 0);
    issue(FN_ASSIGN, 5, 0);                        // already used
    issue(FN_ASSIGN, CAPACITY, 0);                 // just beyond the pool
    issue(FN_ASSIGN, 65535, 65535);
    issue(FN_RETURN, 65535, 0);                    // ignored beyond the pool
    issue(FN_RETURN, 1, 0);
    issue(FN_RETURN, 1, 0);                        // already free, harmless
    issue(FN_ASSIGN_RANGE, 100, 99);               // reversed
    issue(FN_RETURN_RANGE, 65535, 0);              // reversed
    issue(FN_ASSIGN_RANGE, 10, CAPACITY);          // crosses the pool end
    issue(FN_ASSIGN_RANGE, 0, CAPACITY - 1);       // clashes with 0
    issue(FN_RETURN_RANGE, CAPACITY - 96, 65535);
    issue(FN_ASSIGN_RANGE, 64, 127);               // fills one word exactly
    issue(FN_LEND, 0, 0);                          // lowest free: 1, ahead of the full word
    issue(FN_RETURN_RANGE, 0, CAPACITY - 1);
    issue(FN_ASSIGN_RANGE, 0, CAPACITY - 1);       // whole pool
    issue(FN_LEND, 0, 0);                          // pool full
    issue(FN_RETURN, CAPACITY - 1, 0);
    issue(FN_LEND, 0, 0);                          // last number in the pool
    issue(FN_RETURN, 130, 0);
    issue(FN_LEND, 0, 0);
    issue(FN_UNUSED_FIRST, 7, 9);
    issue(FN_UNUSED_FIRST + 3'd1, 65535, 0);
    issue(FN_UNUSED_LAST, 0, 65535);
    issue(FN_RETURN_RANGE, 0, 65535);

    // Random part; idling switches on and off in stretches and stops at the end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (k >= RANDOM_ITEMS - QUIET_ITEMS) gaps_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel == 0) begin
        // Drive the pool to full, then probe it
        issue(FN_RETURN_RANGE, 0, CAPACITY - 1);
        issue(FN_ASSIGN_RANGE, 0, CAPACITY - 1);
        issue(FN_LEND, 0, 0);
      end else if (sel < 31) begin
        issue(FN_LEND, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (sel < 50) begin
        issue(FN_RETURN, pick_number(), $urandom_range(0, 65535));
      end else if (sel < 64) begin
        issue(FN_ASSIGN, pick_number(), $urandom_range(0, 65535));
      end else if (sel < 79) begin
        pick_range(s, e);
        issue(FN_ASSIGN_RANGE, s, e);
      end else if (sel < 94) begin
        pick_range(s, e);
        issue(FN_RETURN_RANGE, s, e);
      end else begin
        issue(pick_unused_func(), 0, 0);
      end
    end

    start <= 1'b0;
    @(posedge clk);

    // Drain: wait for every expected result, bounded
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Hold a little longer to catch any stray result
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (outstanding == 0 && fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
